/* hw/rtl/vsrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsrc_pkg: shared types and constants for video slice reassembly control
// Header, context and result records plus protocol constants.
// ----------------------------------------------------------------------------
package vsrc_pkg;

	// protocol constants
	localparam logic [7:0]  MAGIC_BYTE      = 8'h5A;
	localparam logic [7:0]  TYPE_TELEMETRY  = 8'h01;
	localparam logic [7:0]  TYPE_VIDEO      = 8'h02;
	localparam logic [22:0] FRAME_CAP       = 23'd4194304;
	localparam int          HEADER_BYTES    = 12;
	localparam int          SLICE_MAX_BYTES = 1024;

	// result codes
	typedef enum logic [2:0] {
		OUT_IGNORED   = 3'd0,
		OUT_TELEMETRY = 3'd1,
		OUT_ACCEPTED  = 3'd2,
		OUT_COMPLETE  = 3'd3,
		OUT_DISCARD   = 3'd4
	} outcome_t;

	// decoded packet header
	typedef struct packed {
		logic [7:0]  magic;
		logic [7:0]  packet_type;
		logic [15:0] packet_len;
		logic [15:0] seq_num;
		logic [15:0] frame_num;
		logic [15:0] slice_num;
		logic [31:0] frame_total;
	} hdr_t;

	// reassembly context
	typedef struct packed {
		logic [15:0] cur_frame;
		logic [15:0] expected_slice;
		logic [15:0] last_seq;
		logic [22:0] target_total;
		logic [22:0] fill_count;
	} ctx_t;

	// per-packet result
	typedef struct packed {
		outcome_t    outcome;
		logic [22:0] write_offset;
		logic [10:0] slice_len;
		logic [22:0] frame_len;
	} res_t;

endpackage
`default_nettype wire

/* hw/rtl/vsrc_state.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsrc_state: reassembly context and frame size limit registers
// Holds the frame context and the max frame size register, and derives the
// limit in effect.
// ----------------------------------------------------------------------------
module vsrc_state (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              upd,
	input  wire vsrc_pkg::ctx_t    ctx_nxt,
	input  wire logic              cfg_wr_en,
	input  wire logic [22:0]       cfg_wr_data,
	output vsrc_pkg::ctx_t         ctx,
	output logic [22:0]            limit
);

	vsrc_pkg::ctx_t ctx_q;
	logic [22:0]    max_frame_bytes_q;

	// context update on each processed video packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= '0;
		end else if (upd) begin
			ctx_q <= ctx_nxt;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_bytes_q <= vsrc_pkg::FRAME_CAP;
		end else if (cfg_wr_en) begin
			max_frame_bytes_q <= cfg_wr_data;
		end
	end

	assign ctx   = ctx_q;
	// clamp to the frame store size
	assign limit = (max_frame_bytes_q < vsrc_pkg::FRAME_CAP) ? max_frame_bytes_q
	                                                          : vsrc_pkg::FRAME_CAP;

endmodule
`default_nettype wire

/* hw/rtl/vsrc_decide.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vsrc_decide: per-packet header decision
// Validates one header against the context and produces the result and the
// next context.
// ----------------------------------------------------------------------------
module vsrc_decide (
	input  wire vsrc_pkg::hdr_t    hdr,
	input  wire vsrc_pkg::ctx_t    ctx,
	input  wire logic [22:0]       limit,
	output vsrc_pkg::res_t         res,
	output vsrc_pkg::ctx_t         ctx_nxt,
	output logic                   upd
);

	localparam logic [15:0] HDR_LEN   = 16'(vsrc_pkg::HEADER_BYTES);
	localparam logic [15:0] SLICE_MAX = 16'(vsrc_pkg::SLICE_MAX_BYTES);

	logic        base_ok;
	logic        video_ok;
	logic [15:0] bytes;
	logic        first;
	logic [15:0] eff_cur;
	logic [15:0] eff_exp;
	logic [22:0] eff_target;
	logic [22:0] eff_fill;
	logic [15:0] seq_inc;
	logic        brk;
	logic [23:0] sum;
	logic        ovf;
	logic        done;

	// header screening
	assign base_ok  = (hdr.packet_len >= 16'd2) && (hdr.magic == vsrc_pkg::MAGIC_BYTE);
	assign bytes    = hdr.packet_len - HDR_LEN;
	assign video_ok = base_ok && (hdr.packet_type == vsrc_pkg::TYPE_VIDEO)
	               && (hdr.packet_len > HDR_LEN) && (bytes <= SLICE_MAX)
	               && (hdr.frame_total != 32'd0)
	               && (hdr.frame_total <= {9'd0, limit});

	// slice 0 opens a new frame before the continuity checks
	assign first      = (hdr.slice_num == 16'd0);
	assign eff_cur    = first ? hdr.frame_num : ctx.cur_frame;
	assign eff_exp    = first ? 16'd0 : ctx.expected_slice;
	assign eff_target = first ? hdr.frame_total[22:0] : ctx.target_total;
	assign eff_fill   = first ? 23'd0 : ctx.fill_count;

	// continuity and overflow
	assign seq_inc = ctx.last_seq + 16'd1;
	assign brk     = (hdr.frame_num != eff_cur) || (hdr.slice_num != eff_exp)
	              || ((eff_exp != 16'd0) && (seq_inc != hdr.seq_num));
	assign sum     = {1'b0, eff_fill} + {8'd0, bytes};
	assign ovf     = (sum > {1'b0, eff_target});
	assign done    = (sum[22:0] == eff_target);

	assign upd = video_ok;

	// result and next context
	always_comb begin
		res                    = '0;
		res.outcome            = vsrc_pkg::OUT_IGNORED;
		ctx_nxt                = ctx;
		ctx_nxt.cur_frame      = eff_cur;
		ctx_nxt.expected_slice = eff_exp;
		ctx_nxt.target_total   = eff_target;
		ctx_nxt.fill_count     = eff_fill;
		if (base_ok && (hdr.packet_type == vsrc_pkg::TYPE_TELEMETRY)) begin
			res.outcome = vsrc_pkg::OUT_TELEMETRY;
		end else if (video_ok) begin
			if (brk || ovf) begin
				res.outcome            = vsrc_pkg::OUT_DISCARD;
				ctx_nxt.expected_slice = 16'd0;
				ctx_nxt.target_total   = 23'd0;
				ctx_nxt.fill_count     = 23'd0;
			end else begin
				res.write_offset = eff_fill;
				res.slice_len    = bytes[10:0];
				ctx_nxt.last_seq = hdr.seq_num;
				if (done) begin
					res.outcome            = vsrc_pkg::OUT_COMPLETE;
					res.frame_len          = eff_target;
					ctx_nxt.expected_slice = 16'd0;
					ctx_nxt.target_total   = 23'd0;
					ctx_nxt.fill_count     = 23'd0;
				end else begin
					res.outcome            = vsrc_pkg::OUT_ACCEPTED;
					ctx_nxt.expected_slice = eff_exp + 16'd1;
					ctx_nxt.fill_count     = sum[22:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/video_slice_reassembly_control_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path: an accepted header beat is held in the input register, then its
// decision lands in the result register.
// Throughput: one header per cycle unless m_tready stalls the result beat; the
// context is read and updated in the same cycle as the decision, so no gaps.
// Reset: arst_n clears context, valid flags and sets max_frame_bytes to 4 MiB.
// ----------------------------------------------------------------------------
// video_slice_reassembly_control_top: header control for frame reassembly
// Checks each packet header, tracks slice and sequence continuity and reports
// store offsets, frame completion and discards.
// ----------------------------------------------------------------------------
module video_slice_reassembly_control_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	// slave side: header beats
	input  wire logic          s_tvalid,
	output logic               s_tready,
	// magic[7:0], packet_len[23:8], seq_num[39:24], frame_num[55:40],
	// slice_num[71:56], frame_total[103:72]
	input  wire logic [103:0]  s_tdata,
	// packet_type[7:0]
	input  wire logic [7:0]    s_tuser,
	// master side: result beats
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// write_offset[22:0], slice_len[33:23], frame_len[56:34], zero[63:57]
	output logic [63:0]        m_tdata,
	// outcome[2:0]
	output logic [2:0]         m_tuser,
	// configuration
	input  wire logic          cfg_wr_en,
	input  wire logic [22:0]   cfg_wr_data
);

	vsrc_pkg::hdr_t hdr_s1;
	logic           valid_s1;
	vsrc_pkg::res_t res_q;
	logic           out_valid_q;
	logic           adv;
	logic           in_acc;

	vsrc_pkg::ctx_t ctx;
	vsrc_pkg::ctx_t ctx_nxt;
	vsrc_pkg::res_t res;
	logic [22:0]    limit;
	logic           upd;

	// handshake
	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign in_acc   = s_tvalid && s_tready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			hdr_s1.magic       <= s_tdata[7:0];
			hdr_s1.packet_type <= s_tuser;
			hdr_s1.packet_len  <= s_tdata[23:8];
			hdr_s1.seq_num     <= s_tdata[39:24];
			hdr_s1.frame_num   <= s_tdata[55:40];
			hdr_s1.slice_num   <= s_tdata[71:56];
			hdr_s1.frame_total <= s_tdata[103:72];
		end
	end

	vsrc_decide u_decide (
		.hdr     (hdr_s1),
		.ctx     (ctx),
		.limit   (limit),
		.res     (res),
		.ctx_nxt (ctx_nxt),
		.upd     (upd)
	);

	vsrc_state u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd         (adv && upd),
		.ctx_nxt     (ctx_nxt),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.ctx         (ctx),
		.limit       (limit)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.outcome;
	assign m_tdata  = {7'd0, res_q.frame_len, res_q.slice_len, res_q.write_offset};

	// checks
	ast_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		ctx.fill_count <= ctx.target_total)
		else $error("fill count beyond frame total");

	ast_flen_only_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res_q.frame_len != 23'd0)) |-> (res_q.outcome == vsrc_pkg::OUT_COMPLETE))
		else $error("frame length on a non-complete result");

	ast_len_only_stored: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (res_q.slice_len != 11'd0)) |->
		((res_q.outcome == vsrc_pkg::OUT_ACCEPTED) || (res_q.outcome == vsrc_pkg::OUT_COMPLETE)))
		else $error("slice length on a result that stores nothing");

	ast_ctx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctx))
		else $error("context changed without a processed header");

endmodule
`default_nettype wire
